// ----- hw/rtl/tbfb_pkg.sv -----
// shared types, constants and the delimiter function of the token bloom filter builder
package tbfb_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 7;
  localparam int HASH_W = 32;
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;

  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_END   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  localparam hash_t DJB_INIT  = 32'd5381;
  localparam hash_t FNV_INIT  = 32'd2166136261;
  localparam hash_t FNV_PRIME = 32'd16777619;
  localparam hash_t SDBM_INIT = 32'd0;

  function automatic logic is_delim(input logic [BYTE_W-1:0] c);
    return c == 8'h20 || c == 8'h22 || c == 8'h3a || c == 8'h0a || c == 8'h0d ||
           c == 8'h09 || c == 8'h2c || c == 8'h7b || c == 8'h7d || c == 8'h5b ||
           c == 8'h5d;
  endfunction

endpackage

// ----- hw/rtl/tbfb_hash_mod.sv -----
// three-stage pipeline that reduces a 32-bit hash modulo the filter size
module tbfb_hash_mod #(
  parameter int BLOOM_BITS = 8192
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          flush,
  input  logic                          in_vld,
  input  tbfb_pkg::hash_t               hash,
  output logic                          busy,
  output logic                          out_vld,
  output logic [$clog2(BLOOM_BITS)-1:0] bit_idx
);
  import tbfb_pkg::*;

  localparam int NW = $clog2(BLOOM_BITS);
  localparam longint unsigned RECIP_L = (64'd1 << HASH_W) / 64'(BLOOM_BITS);
  localparam int RW = $clog2(RECIP_L + 1);
  localparam int PW = HASH_W + RW;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
  localparam logic [NW:0] DIV = (NW+1)'(BLOOM_BITS);

  logic          v1, v2;
  hash_t         x1, x2, p2;
  logic [PW-1:0] p1;
  logic [RW-1:0] q;
  logic [NW:0]   rem, rem_adj;

  // quotient estimate is low by at most one
  assign q       = p1[PW-1:HASH_W];
  assign rem     = (NW+1)'(x2 - p2);
  assign rem_adj = (rem >= DIV) ? rem - DIV : rem;
  assign busy    = v1 || v2 || out_vld;

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1      <= in_vld;
      v2      <= v1;
      out_vld <= v2;
    end
  end

  always_ff @(posedge clk) begin
    x1      <= hash;
    p1      <= PW'(hash) * PW'(RECIP);
    x2      <= x1;
    p2      <= HASH_W'(64'(q) * 64'(BLOOM_BITS));
    bit_idx <= NW'(rem_adj);
  end

endmodule

// ----- hw/rtl/token_bloom_filter_builder.sv -----
// top level: tokenizer, hashes, insert queue and bloom word memory
// Bytes are taken one per cycle while a token runs. A token end loads three
// filter-bit inserts that go one per cycle through a shared modulo pipeline
// and a read-modify-write of the word memory (one read port, one write port,
// with forwarding between back-to-back writes); a further token end is held
// until at most one insert of the previous one is left. A word read waits
// until all inserts have landed; its result passes through the registered
// memory read and then the output register. A clear resets the valid bit
// that each word carries, and the in-flight inserts and any open token are
// dropped. Reads beyond the last filter word return zero.
module token_bloom_filter_builder #(
  parameter int BLOOM_BITS = 8192
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tbfb_pkg::op_t                op,
  input  logic [tbfb_pkg::BYTE_W-1:0]  data_byte,
  input  logic [tbfb_pkg::IDX_W-1:0]   word_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tbfb_pkg::word_t              bloom_word
);
  import tbfb_pkg::*;

  localparam int BLOOM_WORDS = (BLOOM_BITS + WORD_W - 1) / WORD_W;
  localparam int MAX_WORDS   = 1 << IDX_W;
  localparam int STORE_WORDS = (BLOOM_WORDS < MAX_WORDS) ? BLOOM_WORDS : MAX_WORDS;
  localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int NW          = $clog2(BLOOM_BITS);
  localparam int WW          = (NW > BIT_W) ? NW - BIT_W : 1;

  hash_t djb, fnv, sdbm;
  hash_t djb_next, fnv_next, sdbm_next;
  logic  in_token;
  hash_t ph0, ph1, ph2;
  logic [1:0] pend_cnt;

  logic is_del, close_req, accept;
  logic do_close, do_clear, do_read, do_hash;
  logic feed_vld, pipe_busy, n_vld;
  logic [NW-1:0] n;
  logic [WW-1:0] word3;
  logic          in_store;

  logic             v4;
  logic [AW-1:0]    a4;
  logic [BIT_W-1:0] b4;
  logic [AW-1:0]    rd_addr;
  word_t            mem [STORE_WORDS];
  word_t            rdata, base, wr_data;
  logic             mem_we;
  logic [STORE_WORDS-1:0] vld;
  logic             fw_v;
  logic [AW-1:0]    fw_a;
  word_t            fw_d;
  logic             rd_pend, rd_hit;

  assign is_del    = is_delim(data_byte);
  assign close_req = in_token && ((op == OP_DATA && is_del) || op == OP_END);

  always_comb begin
    case (op)
      OP_DATA, OP_END: in_ready = !close_req || pend_cnt <= 2'd1;
      OP_READ: in_ready = pend_cnt == 2'd0 && !pipe_busy && !v4 && !rd_pend &&
                          (!out_valid || out_ready);
      OP_CLEAR: in_ready = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  assign accept   = in_valid && in_ready;
  assign do_close = accept && close_req;
  assign do_clear = accept && op == OP_CLEAR;
  assign do_read  = accept && op == OP_READ;
  assign do_hash  = accept && op == OP_DATA && !is_del;

  // running hashes
  assign djb_next  = (djb << 5) + djb + HASH_W'(data_byte);
  assign fnv_next  = (fnv ^ HASH_W'(data_byte)) * FNV_PRIME;
  assign sdbm_next = HASH_W'(data_byte) + (sdbm << 6) + (sdbm << 16) - sdbm;

  always_ff @(posedge clk) begin
    if (rst || do_clear || do_close) begin
      djb      <= DJB_INIT;
      fnv      <= FNV_INIT;
      sdbm     <= SDBM_INIT;
      in_token <= 1'b0;
    end else if (do_hash) begin
      djb      <= djb_next;
      fnv      <= fnv_next;
      sdbm     <= sdbm_next;
      in_token <= 1'b1;
    end
  end

  // insert queue of one token
  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      pend_cnt <= 2'd0;
    end else if (do_close) begin
      pend_cnt <= 2'd3;
    end else if (pend_cnt != 2'd0) begin
      pend_cnt <= pend_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_close) begin
      ph0 <= djb;
      ph1 <= fnv;
      ph2 <= sdbm;
    end else if (pend_cnt != 2'd0) begin
      ph0 <= ph1;
      ph1 <= ph2;
    end
  end

  assign feed_vld = pend_cnt != 2'd0;

  tbfb_hash_mod #(
    .BLOOM_BITS(BLOOM_BITS)
  ) u_mod (
    .clk    (clk),
    .rst    (rst),
    .flush  (do_clear),
    .in_vld (feed_vld),
    .hash   (ph0),
    .busy   (pipe_busy),
    .out_vld(n_vld),
    .bit_idx(n)
  );

  assign word3    = WW'(n >> BIT_W);
  assign in_store = 32'(word3) < 32'(STORE_WORDS);

  // read issue stage
  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      v4 <= 1'b0;
    end else begin
      v4 <= n_vld && in_store;
    end
  end

  always_ff @(posedge clk) begin
    a4 <= AW'(word3);
    b4 <= n[BIT_W-1:0];
  end

  assign rd_addr = n_vld ? AW'(word3) : word_index[AW-1:0];

  // modify and write back
  always_comb begin
    if (fw_v && fw_a == a4) begin
      base = fw_d;
    end else if (vld[a4]) begin
      base = rdata;
    end else begin
      base = '0;
    end
  end

  assign wr_data = base | (word_t'(1) << b4);
  assign mem_we  = v4 && !do_clear;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[a4] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      vld  <= '0;
      fw_v <= 1'b0;
    end else begin
      if (mem_we) begin
        vld[a4] <= 1'b1;
      end
      fw_v <= mem_we;
    end
  end

  always_ff @(posedge clk) begin
    fw_a <= a4;
    fw_d <= wr_data;
  end

  // word read and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= do_read;
    end
  end

  always_ff @(posedge clk) begin
    rd_hit <= (32'(word_index) < 32'(STORE_WORDS)) && vld[word_index[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pend) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      bloom_word <= rd_hit ? rdata : '0;
    end
  end

endmodule
